[design/sgts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sgts_pkg;
	localparam int unsigned QW = 16;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {
		CFG_SIZE_X  = 2'd0,
		CFG_SIZE_Y  = 2'd1,
		CFG_SIZE_Z  = 2'd2,
		CFG_THREE_D = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_BLEND_Y,
		BK_BLEND_X,
		BK_BLEND_Z,
		BK_DONE
	} bk_state_t;

	// Axis setup result.
	typedef struct packed {
		logic [7:0]  base;
		logic [16:0] w1;
	} axis_t;

	function automatic axis_t axis_setup(input logic [23:0] pos, input logic [8:0] n);
		logic signed [24:0] p;
		logic [8:0] i;
		logic [16:0] f;
		axis_t r;
		p = $signed({pos[23], pos}) - 25'sd32768;
		i = '0;
		f = '0;
		if (!p[24]) begin
			i = {1'b0, p[23:16]};
			f = {1'b0, p[15:0]};
		end
		if (i + 9'd1 >= n) begin
			i = n - 9'd2;
			f = ONE_Q16;
		end
		r.base = i[7:0];
		r.w1 = f;
		return r;
	endfunction
endpackage
`default_nettype wire

[design/sgts_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Classifies requests: in-grid writes and samples both take a queue slot, in order.
module sgts_front import sgts_pkg::*; #(
	parameter int MAX_X = 32,
	parameter int MAX_Y = 32,
	parameter int MAX_Z = 32,
	parameter int BATCHES = 2,
	localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1,
	localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1,
	localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1,
	localparam int BW = (BATCHES > 1) ? $clog2(BATCHES) : 1,
	localparam int AW = BW + ZW + YW + XW,
	localparam int QDW = 1 + 32 + 1 + AW + XW + YW + ZW + 3*17
) (
	input  wire logic req,
	input  wire logic cmd,
	input  wire logic batch,
	input  wire logic [4:0] cell_x,
	input  wire logic [4:0] cell_y,
	input  wire logic [4:0] cell_z,
	input  wire logic [31:0] cell_value,
	input  wire logic [23:0] pos_x,
	input  wire logic [23:0] pos_y,
	input  wire logic [23:0] pos_z,
	input  wire logic [5:0] size_x,
	input  wire logic [5:0] size_y,
	input  wire logic [5:0] size_z,
	input  wire logic three_d,
	output logic q_push,
	output logic [QDW-1:0] q_data
);
	logic [8:0] nx, ny, nz;
	logic d3;
	axis_t ax, ay, az;
	logic [BW-1:0] b;
	logic [8:0] zb;
	logic ok, wr_ok;
	logic [AW-1:0] addr;

	always_comb begin
		nx = (size_x < 6'd2) ? 9'd2 : ({3'd0, size_x} > 9'(MAX_X)) ? 9'(MAX_X) : {3'd0, size_x};
		ny = (size_y < 6'd2) ? 9'd2 : ({3'd0, size_y} > 9'(MAX_Y)) ? 9'(MAX_Y) : {3'd0, size_y};
		nz = (size_z < 6'd1) ? 9'd1 : ({3'd0, size_z} > 9'(MAX_Z)) ? 9'(MAX_Z) : {3'd0, size_z};
		d3 = three_d && (MAX_Z >= 2);
		if (d3 && nz < 9'd2)
			nz = 9'd2;
		b = BW'(batch);
		ax = axis_setup(pos_x, nx);
		ay = axis_setup(pos_y, ny);
		az = axis_setup(pos_z, nz);
		zb = d3 ? {1'b0, az.base} : 9'd0;
		ok = {31'd0, batch} < 32'(BATCHES);
		wr_ok = ok && ({4'd0, cell_x} < nx) && ({4'd0, cell_y} < ny) && ({4'd0, cell_z} < nz);
		addr = cmd ? {b, zb[ZW-1:0], ay.base[YW-1:0], ax.base[XW-1:0]}
			: {b, cell_z[ZW-1:0], cell_y[YW-1:0], cell_x[XW-1:0]};
		// out-of-grid writes are dropped here
		q_push = req && (cmd || wr_ok);
		// {sample, write data, valid batch, cell addr, x/y/z base, weights}
		q_data = {cmd, cell_value, ok, addr,
			ax.base[XW-1:0], ay.base[YW-1:0], zb[ZW-1:0],
			ax.w1, ay.w1, (d3 ? az.w1 : 17'd0)};
	end
endmodule
`default_nettype wire

[design/sgts_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Retires queued writes; for a sample reads eight (or four) cells one per cycle,
// then blends y, x and, in 3D, z in turn.
module sgts_back import sgts_pkg::*; #(
	parameter int MAX_X = 32,
	parameter int MAX_Y = 32,
	parameter int MAX_Z = 32,
	parameter int BATCHES = 2,
	localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1,
	localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1,
	localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1,
	localparam int BW = (BATCHES > 1) ? $clog2(BATCHES) : 1,
	localparam int AW = BW + ZW + YW + XW,
	localparam int QDW = 1 + 32 + 1 + AW + XW + YW + ZW + 3*17
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic three_d_en,
	input  wire logic q_valid,
	input  wire logic [QDW-1:0] q_data,
	output logic q_pop,
	output logic done,
	output logic [31:0] sample_value
);
	localparam int DEPTH = 1 << AW;
	logic [31:0] mem [DEPTH];
	logic [31:0] rd_q;
	logic [AW-1:0] rd_addr;

	bk_state_t st_q, st_d;
	logic [3:0] cnt_q;
	logic [QDW-1:0] job_q;
	logic signed [31:0] c_q [8];
	logic signed [31:0] v_q [4];
	logic [1:0] bcnt_q;
	logic d3_q;

	// head-of-queue write, retired while idle so it stays behind earlier samples
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0] wr_data;
	assign wr_en = (st_q == BK_IDLE) && q_valid && !q_data[QDW-1];
	assign wr_data = q_data[QDW-2 -: 32];
	assign wr_addr = q_data[QDW-35 -: AW];

	logic ok;
	logic [AW-1:0] base;
	logic [16:0] sx, ty, fz;
	assign {ok, base} = job_q[QDW-34 -: AW+1];
	assign sx = job_q[50:34];
	assign ty = job_q[33:17];
	assign fz = job_q[16:0];

	// cell order k = {dz,dx,dy}
	logic [2:0] k;
	assign k = cnt_q[2:0];
	always_comb begin
		rd_addr = base;
		rd_addr = rd_addr + (AW'(k[0]) << XW) + AW'(k[1])
			+ (AW'(k[2]) << (XW + YW));
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// blend operands
	logic signed [31:0] ba, bb;
	logic [16:0] bw;
	logic signed [50:0] bs;
	logic signed [31:0] bres;
	always_comb begin
		ba = c_q[0];
		bb = c_q[1];
		bw = ty;
		unique case (st_q)
			BK_BLEND_Y: begin
				ba = c_q[{bcnt_q, 1'b0}];
				bb = c_q[{bcnt_q, 1'b1}];
				bw = ty;
			end
			BK_BLEND_X: begin
				ba = v_q[{bcnt_q[0], 1'b0}];
				bb = v_q[{bcnt_q[0], 1'b1}];
				bw = sx;
			end
			BK_BLEND_Z: begin
				ba = v_q[0];
				bb = v_q[1];
				bw = fz;
			end
			default: ;
		endcase
		bs = $signed({{19{ba[31]}}, ba}) * $signed({2'b0, ONE_Q16 - bw})
			+ $signed({{19{bb[31]}}, bb}) * $signed({2'b0, bw}) + 51'sd32768;
		bres = bs[47:16];
	end

	logic [3:0] nread;
	assign nread = d3_q ? 4'd8 : 4'd4;

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		unique case (st_q)
			BK_IDLE: if (q_valid) begin
				q_pop = 1'b1;
				if (q_data[QDW-1])
					st_d = BK_READ;
			end
			BK_READ: if (cnt_q == nread) st_d = BK_BLEND_Y;
			BK_BLEND_Y: if (bcnt_q == (d3_q ? 2'd3 : 2'd1)) st_d = BK_BLEND_X;
			BK_BLEND_X: if (bcnt_q[0] == d3_q) st_d = d3_q ? BK_BLEND_Z : BK_DONE;
			BK_BLEND_Z: st_d = BK_DONE;
			BK_DONE: st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			cnt_q <= '0;
			bcnt_q <= '0;
			done <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= 1'b0;
			if (st_q == BK_IDLE) begin
				cnt_q <= '0;
				bcnt_q <= '0;
			end else if (st_q == BK_READ) begin
				cnt_q <= cnt_q + 4'd1;
			end else if (st_d != st_q) begin
				bcnt_q <= '0;
			end else begin
				bcnt_q <= bcnt_q + 2'd1;
			end
			if (st_q == BK_DONE)
				done <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
			d3_q <= three_d_en;
		end
		if (st_q == BK_READ && cnt_q != 4'd0)
			c_q[3'(cnt_q - 4'd1)] <= rd_q;
		if (st_q == BK_BLEND_Y || st_q == BK_BLEND_X)
			v_q[bcnt_q] <= bres;
		if (st_q == BK_BLEND_Z)
			v_q[0] <= bres;
		if (st_q == BK_DONE)
			sample_value <= ok ? v_q[0] : 32'd0;
	end
endmodule
`default_nettype wire

[design/scalar_grid_trilinear_sampler.sv]
`timescale 1ns / 1ps
`default_nettype none
// Cell-centered clamped trilinear sampler over a per-batch scalar grid.
// In-grid writes and samples enter one two-entry request queue and are carried out
// in order. The back end retires a write as it takes it from the queue; a sample
// is taken from the queue, its 8 cells in 3D (4 in 2D) are read one a cycle from
// the grid memory, which has one read port, then 4 + 2 + 1 blend steps (y, x, z) run in
// 3D (2D skips z and halves the rest) and the result is registered. sample_value is valid for the one
// cycle that done is high; the receiver cannot stall. busy is high while the
// queue is full. Change the configuration only when no request is pending.
module scalar_grid_trilinear_sampler import sgts_pkg::*; #(
	parameter int MAX_X = 32,
	parameter int MAX_Y = 32,
	parameter int MAX_Z = 32,
	parameter int BATCHES = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic cmd,
	input  wire logic batch,
	input  wire logic [4:0] cell_x,
	input  wire logic [4:0] cell_y,
	input  wire logic [4:0] cell_z,
	input  wire logic signed [31:0] cell_value,
	input  wire logic signed [23:0] pos_x,
	input  wire logic signed [23:0] pos_y,
	input  wire logic signed [23:0] pos_z,
	output logic done,
	output logic signed [31:0] sample_value,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [5:0] cfg_data
);
	localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
	localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
	localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
	localparam int BW = (BATCHES > 1) ? $clog2(BATCHES) : 1;
	localparam int AW = BW + ZW + YW + XW;
	localparam int QDW = 1 + 32 + 1 + AW + XW + YW + ZW + 3*17;

	logic [5:0] size_x_q, size_y_q, size_z_q;
	logic three_d_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 6'd32;
			size_y_q <= 6'd32;
			size_z_q <= 6'd1;
			three_d_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SIZE_X:  size_x_q <= cfg_data;
				CFG_SIZE_Y:  size_y_q <= cfg_data;
				CFG_SIZE_Z:  size_z_q <= cfg_data;
				CFG_THREE_D: three_d_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic req, q_push, q_pop;
	logic [QDW-1:0] q_in;
	assign req = start && !busy;

	sgts_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .BATCHES(BATCHES)) u_front (
		.req, .cmd, .batch, .cell_x, .cell_y, .cell_z, .cell_value,
		.pos_x, .pos_y, .pos_z,
		.size_x(size_x_q), .size_y(size_y_q), .size_z(size_z_q), .three_d(three_d_q),
		.q_push, .q_data(q_in)
	);

	// two-entry request queue
	logic [QDW-1:0] qm_q [2];
	logic rp_q, wp_q;
	logic [1:0] cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= 1'b0;
			wp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (q_push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(q_push) - 2'(q_pop);
		end
	end
	always_ff @(posedge clk)
		if (q_push) qm_q[wp_q] <= q_in;
	assign busy = cnt_q == 2'd2;

	sgts_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .BATCHES(BATCHES)) u_back (
		.clk, .arst_n,
		.three_d_en(three_d_q && (MAX_Z >= 2)),
		.q_valid(cnt_q != 2'd0), .q_data(qm_q[rp_q]), .q_pop, .done, .sample_value
	);
endmodule
`default_nettype wire

[bench/scalar_grid_trilinear_sampler_chk.sv]
`timescale 1ns / 1ps
module scalar_grid_trilinear_sampler_chk import sgts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic cmd,
	input  logic batch,
	input  logic [4:0] cell_x,
	input  logic [4:0] cell_y,
	input  logic [4:0] cell_z,
	input  logic signed [31:0] cell_value,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic done,
	input  logic signed [31:0] sample_value,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	output int errors,
	output int pending,
	output int samples_seen,
	output int writes_seen
);
	localparam int MX = 32, MY = 32, MZ = 32;

	logic [31:0] grid [0:65535];
	logic [5:0] sz_x = 6'd32, sz_y = 6'd32, sz_z = 6'd1;
	logic mode_3d = 1'b0;
	logic signed [31:0] expected_values [$];

	function automatic int clampi(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic void split_axis(input logic signed [23:0] pos, input int n,
			output int base, output longint far_w);
		longint p;
		p = longint'(pos) - 32768;
		base = 0;
		far_w = 0;
		if (p >= 0) begin
			base = int'(p >>> 16);
			far_w = p & 65535;
		end
		if (base + 1 >= n) begin
			base = n - 2;
			far_w = 65536;
		end
	endfunction

	// exact weighted sum, rounded half up to Q16.16 (shift is a floor divide)
	function automatic longint mix(longint a, longint b, longint far_w);
		longint s;
		s = a * (65536 - far_w) + b * far_w + 32768;
		return s >>> 16;
	endfunction

	function automatic longint rd(int b, int x, int y, int z);
		return longint'($signed(grid[((b * MZ + z) * MY + y) * MX + x]));
	endfunction

	function automatic longint plane_mix(int b, int x, int y, int z, longint s1, longint t1);
		longint lo, hi;
		lo = mix(rd(b, x, y, z), rd(b, x, y + 1, z), t1);
		hi = mix(rd(b, x + 1, y, z), rd(b, x + 1, y + 1, z), t1);
		return mix(lo, hi, s1);
	endfunction

	function automatic logic signed [31:0] interpolate(int b, logic signed [23:0] px,
			logic signed [23:0] py, logic signed [23:0] pz);
		int nx, ny, nz, xi, yi, zi;
		longint s1, t1, f1, r;
		nx = clampi(sz_x, 2, MX);
		ny = clampi(sz_y, 2, MY);
		nz = clampi(sz_z, 1, MZ);
		if (mode_3d && nz < 2) nz = 2;
		split_axis(px, nx, xi, s1);
		split_axis(py, ny, yi, t1);
		if (mode_3d) begin
			split_axis(pz, nz, zi, f1);
			r = mix(plane_mix(b, xi, yi, zi, s1, t1), plane_mix(b, xi, yi, zi + 1, s1, t1), f1);
		end else begin
			r = plane_mix(b, xi, yi, 0, s1, t1);
		end
		return r[31:0];
	endfunction

	initial begin
		errors = 0;
		samples_seen = 0;
		writes_seen = 0;
	end

	assign pending = expected_values.size();

	always @(posedge clk) begin
		int nx, ny, nz;
		logic signed [31:0] want;
		if (arst_n) begin
			// a result leaving now belongs to a request accepted earlier
			if (done) begin
				if (expected_values.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h at %0t", sample_value, $realtime);
				end else begin
					want = expected_values.pop_front();
					samples_seen++;
					if (sample_value !== want) begin
						errors++;
						if (errors <= 10)
							$display("sample_value: expected %h got %h at %0t",
								want, sample_value, $realtime);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SIZE_X:  sz_x = cfg_data;
					CFG_SIZE_Y:  sz_y = cfg_data;
					CFG_SIZE_Z:  sz_z = cfg_data;
					CFG_THREE_D: mode_3d = cfg_data[0];
				endcase
			end
			if (start && !busy) begin
				if (cmd) begin
					expected_values.push_back(interpolate(batch, pos_x, pos_y, pos_z));
				end else begin
					writes_seen++;
					nx = clampi(sz_x, 2, MX);
					ny = clampi(sz_y, 2, MY);
					nz = clampi(sz_z, 1, MZ);
					if (mode_3d && nz < 2) nz = 2;
					if (cell_x < nx && cell_y < ny && cell_z < nz)
						grid[((batch * MZ + cell_z) * MY + cell_y) * MX + cell_x] = cell_value;
				end
			end
		end
	end
endmodule

[bench/scalar_grid_trilinear_sampler_tb.sv]
`timescale 1ns / 1ps
module scalar_grid_trilinear_sampler_tb import sgts_pkg::*;;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cmd = 1'b0;
	logic batch = 1'b0;
	logic [4:0] cell_x = '0, cell_y = '0, cell_z = '0;
	logic signed [31:0] cell_value = '0;
	logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic done;
	logic signed [31:0] sample_value;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;
	int errors, pending, samples_seen, writes_seen;

	// effective sizes of the current setting, for fill and position ranges
	int nx, ny, nz;
	// batch slots that samples may use under the current setting
	int nb = 2;
	int burst_left = 0;
	// cells already written once, so a fill skips them
	bit filled [0:65535];

	always #4 clk = ~clk;

	scalar_grid_trilinear_sampler DUT (.*);

	scalar_grid_trilinear_sampler_chk u_chk (.*);

	task automatic write_reg(cfg_idx_t idx, logic [5:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drive one request at a negedge, after an optional idle gap, and hold it until taken
	task automatic issue(logic c, logic b, logic [4:0] x, logic [4:0] y, logic [4:0] z,
			logic [31:0] v, logic [23:0] px, logic [23:0] py, logic [23:0] pz);
		logic was_busy;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : 0) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		cmd <= c;
		batch <= b;
		cell_x <= x;
		cell_y <= y;
		cell_z <= z;
		cell_value <= v;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		do begin
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
		@(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_mode(logic [5:0] sx, logic [5:0] sy, logic [5:0] sz, logic d3,
			int batches);
		drain();
		write_reg(CFG_SIZE_X, sx);
		write_reg(CFG_SIZE_Y, sy);
		write_reg(CFG_SIZE_Z, sz);
		write_reg(CFG_THREE_D, {5'd0, d3});
		nx = (sx < 2) ? 2 : (sx > 32) ? 32 : sx;
		ny = (sy < 2) ? 2 : (sy > 32) ? 32 : sy;
		nz = (sz < 1) ? 1 : (sz > 32) ? 32 : sz;
		if (d3 && nz < 2) nz = 2;
		if (!d3) nz = 1;
		nb = batches;
		// every cell a sample can reach gets written before any sample
		for (int b = 0; b < batches; b++)
			for (int z = 0; z < nz; z++)
				for (int y = 0; y < ny; y++)
					for (int x = 0; x < nx; x++)
						if (!filled[((b * 32 + z) * 32 + y) * 32 + x]) begin
							filled[((b * 32 + z) * 32 + y) * 32 + x] = 1'b1;
							issue(1'b0, 1'(b), 5'(x), 5'(y), 5'(z), $urandom,
								24'd0, 24'd0, 24'd0);
						end
	endtask

	function automatic logic [23:0] rand_pos(int n);
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return ($urandom_range(0, n - 1) << 16) + 32768;
			default: return $urandom_range(0, (n + 2) * 65536) - 65536;
		endcase
	endfunction

	task automatic random_items(int count);
		repeat (count) begin
			if ($urandom_range(0, 9) < 6)
				issue(1'b1, 1'($urandom_range(0, nb - 1)), $urandom, $urandom, $urandom,
					$urandom, rand_pos(nx), rand_pos(ny), rand_pos(nz));
			else if ($urandom_range(0, 3) == 0)
				issue(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
			else
				issue(1'b0, $urandom, $urandom_range(0, nx - 1), $urandom_range(0, ny - 1),
					$urandom_range(0, nz - 1), $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// smallest 3D grid: corners, clamping and extreme values
		set_mode(6'd2, 6'd2, 6'd2, 1'b1, 2);
		issue(1'b0, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0);
		issue(1'b0, 0, 1, 1, 1, 32'h7fff_ffff, 0, 0, 0);
		issue(1'b0, 1, 1, 0, 1, 32'hffff_ffff, 0, 0, 0);
		issue(1'b0, 0, 2, 0, 0, 32'h1234_5678, 0, 0, 0);      // outside x, dropped
		issue(1'b0, 1, 0, 0, 31, 32'h1234_5678, 0, 0, 0);     // outside z, dropped
		issue(1'b1, 0, 0, 0, 0, 0, 24'h800000, 24'h800000, 24'h800000);
		issue(1'b1, 0, 0, 0, 0, 0, 24'h7fffff, 24'h7fffff, 24'h7fffff);
		issue(1'b1, 0, 0, 0, 0, 0, 24'h008000, 24'h008000, 24'h008000);
		issue(1'b1, 0, 0, 0, 0, 0, 24'h018000, 24'h018000, 24'h018000);
		issue(1'b1, 0, 0, 0, 0, 0, 24'h010000, 24'h010000, 24'h010000);
		issue(1'b1, 1, 0, 0, 0, 0, 24'h000000, 24'h00ffff, 24'h00c000);
		issue(1'b1, 1, 0, 0, 0, 0, 24'hffffff, 24'h007fff, 24'h008001);
		issue(1'b1, 1, 0, 0, 0, 0, 24'h555555, 24'haaaaaa, 24'h0f0f0f);
		random_items(50);

		set_mode(6'd0, 6'd1, 6'd0, 1'b1, 2);
		random_items(40);
		set_mode(6'd5, 6'd3, 6'd1, 1'b0, 2);
		random_items(40);
		set_mode(6'd63, 6'd0, 6'd7, 1'b0, 1);
		random_items(40);
		set_mode(6'd2, 6'd2, 6'd63, 1'b1, 1);
		random_items(40);
		set_mode(6'd7, 6'd4, 6'd3, 1'b1, 2);
		random_items(40);
		set_mode(6'd3, 6'd9, 6'd0, 1'b0, 2);
		random_items(30);
		drain();

		$display("Checked %0d samples after %0d cell writes over seven grid settings,",
			samples_seen, writes_seen);
		$display("2D and 3D, sizes from the clamped minimum to the full grid width.");
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
